### hw/rtl/rbp_pkg.sv
// Shared types, constants and the divider step for the ray-to-border projection core.
`timescale 1ns / 1ps
package rbp_pkg;

    localparam int CW = 10;            // coordinate width
    localparam int EW = 4;             // edge code width
    localparam int RW = 2 * CW;        // divider remainder width
    localparam int BPS = 2;            // quotient bits per divider stage
    localparam int DIV_STAGES = CW / BPS;

    typedef enum logic [EW-1:0] {
        EDGE_NONE         = 4'd0,
        EDGE_TOP_LEFT     = 4'd1,
        EDGE_LEFT_TOP     = 4'd2,
        EDGE_LEFT_BOTTOM  = 4'd3,
        EDGE_BOTTOM_LEFT  = 4'd4,
        EDGE_BOTTOM_RIGHT = 4'd5,
        EDGE_RIGHT_BOTTOM = 4'd6,
        EDGE_RIGHT_TOP    = 4'd7,
        EDGE_TOP_RIGHT    = 4'd8
    } t_edge;

    typedef enum logic [3:0] {
        DIR_SAME,
        DIR_COL_DN,
        DIR_COL_UP,
        DIR_ROW_R,
        DIR_ROW_L,
        DIR_UL,
        DIR_DL,
        DIR_DR,
        DIR_UR
    } t_dir;

    typedef struct packed {
        logic          div_on;   // one coordinate comes from the divider
        logic          to_x;     // divider result goes to the column
        logic          raise;    // a zero quotient reads as one
        t_edge         code;
        logic [CW-1:0] bx;
        logic [CW-1:0] by;
        logic [CW-1:0] den;
        logic          neg;
        logic          ovf;
        logic [RW-1:0] rem;
        logic [CW-1:0] q;
    } t_work;

    // One restoring step: try den << b against the partial remainder.
    function automatic t_work div_step(input t_work w, input int b);
        logic [RW:0] sh;
        logic [RW:0] diff;
        t_work       r;
        r    = w;
        sh   = (RW+1)'(w.den) << b;
        diff = {1'b0, w.rem} - sh;
        if (!diff[RW]) begin
            r.rem = diff[RW-1:0];
            r.q   = w.q | (CW'(1) << b);
        end
        return r;
    endfunction

endpackage

### hw/rtl/rbp_if.sv
// Valid/ready channel interfaces for viewer/target beats and border beats.
`timescale 1ns / 1ps
interface rbp_in_if import rbp_pkg::*; ();
    logic          valid;
    logic          ready;
    logic [CW-1:0] viewer_x;
    logic [CW-1:0] viewer_y;
    logic [CW-1:0] target_x;
    logic [CW-1:0] target_y;

    modport source (output valid, viewer_x, viewer_y, target_x, target_y, input ready);
    modport sink   (input valid, viewer_x, viewer_y, target_x, target_y, output ready);
endinterface

interface rbp_out_if import rbp_pkg::*; ();
    logic          valid;
    logic          ready;
    logic [CW-1:0] border_x;
    logic [CW-1:0] border_y;
    logic [EW-1:0] edge_code;

    modport source (output valid, border_x, border_y, edge_code, input ready);
    modport sink   (input valid, border_x, border_y, edge_code, output ready);
endinterface

### hw/rtl/ray_to_border_projection_core.sv
// Top level of the ray-to-border projection core.
`timescale 1ns / 1ps
// Casts a ray from the viewer through the target on a FIELD_SIZE square field and
// returns the border point where it leaves the field plus an edge-and-side code.
// Each beat passes through 4 + DIV_STAGES + 1 register stages: products, numerator
// sums, range test and edge select, divider setup, five restoring divider stages at
// two quotient bits each, and the output register. The divider sets the depth;
// throughput is one beat per cycle as long as the sink takes beats. Stages with no
// beat are filled while later stages stall.
module ray_to_border_projection_core import rbp_pkg::*; #(
    parameter int FIELD_SIZE = 800
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rbp_in_if.sink    i_in,
    rbp_out_if.source o_out
);

    localparam int FW = $clog2(FIELD_SIZE + 1);
    localparam int SW = ((FW > CW) ? FW : CW) + 2;
    localparam int NW = FW + CW + 4;
    localparam int NS = 5 + DIV_STAGES;
    localparam int FM1_SAT = (FIELD_SIZE - 1 > 1023) ? 1023 : FIELD_SIZE - 1;
    localparam logic [CW-1:0] LP_FM1 = CW'(FM1_SAT);
    localparam logic [CW-1:0] LP_ONE = CW'(1);
    localparam logic signed [SW-1:0] LP_F = SW'(FIELD_SIZE);

    // Valid bit per stage and load enables; a stage loads when empty or draining.
    logic [NS-1:0] r_v;
    logic [NS-1:0] w_en;

    always_comb begin
        w_en[NS-1] = !r_v[NS-1] || o_out.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign i_in.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // ---- Stage 1: direction class, distances and all products ----
    t_dir                   n1_dir;
    logic [CW-1:0]          n1_dx, n1_dy;
    logic signed [SW-1:0]   n1_fuy, n1_fux;

    always_comb begin
        n1_dx = (i_in.viewer_x > i_in.target_x) ? i_in.viewer_x - i_in.target_x
                                                : i_in.target_x - i_in.viewer_x;
        n1_dy = (i_in.viewer_y > i_in.target_y) ? i_in.viewer_y - i_in.target_y
                                                : i_in.target_y - i_in.viewer_y;
        n1_fuy = LP_F - $signed({{(SW-CW){1'b0}}, i_in.viewer_y});
        n1_fux = LP_F - $signed({{(SW-CW){1'b0}}, i_in.viewer_x});
        priority if (i_in.viewer_x == i_in.target_x) begin
            priority if (i_in.viewer_y < i_in.target_y) n1_dir = DIR_COL_DN;
            else if (i_in.viewer_y > i_in.target_y)     n1_dir = DIR_COL_UP;
            else                                        n1_dir = DIR_SAME;
        end else if (i_in.viewer_y == i_in.target_y) begin
            n1_dir = (i_in.viewer_x < i_in.target_x) ? DIR_ROW_R : DIR_ROW_L;
        end else if (i_in.viewer_y > i_in.target_y) begin
            n1_dir = (i_in.viewer_x > i_in.target_x) ? DIR_UL : DIR_UR;
        end else begin
            n1_dir = (i_in.viewer_x > i_in.target_x) ? DIR_DL : DIR_DR;
        end
    end

    t_dir                 r1_dir;
    logic [CW-1:0]        r1_ux, r1_uy, r1_dx, r1_dy;
    logic signed [NW-1:0] r1_pa, r1_pb, r1_pc, r1_pd, r1_fdx, r1_fdy;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_dir <= n1_dir;
            r1_ux  <= i_in.viewer_x;
            r1_uy  <= i_in.viewer_y;
            r1_dx  <= n1_dx;
            r1_dy  <= n1_dy;
            r1_pa  <= $signed(NW'(i_in.viewer_x) * NW'(n1_dy));
            r1_pb  <= $signed(NW'(i_in.viewer_y) * NW'(n1_dx));
            r1_pc  <= $signed({{(NW-CW){1'b0}}, n1_dx}) * NW'(n1_fuy);
            r1_pd  <= $signed({{(NW-CW){1'b0}}, n1_dy}) * NW'(n1_fux);
            r1_fdx <= $signed(NW'(FIELD_SIZE) * NW'(n1_dx));
            r1_fdy <= $signed(NW'(FIELD_SIZE) * NW'(n1_dy));
        end
    end

    // ---- Stage 2: candidate numerators for the first-tried and the fallback border edge ----
    logic signed [NW-1:0] n2_n1, n2_n2;

    always_comb begin
        unique case (r1_dir)
            DIR_UL: begin
                n2_n1 = r1_pa - r1_pb;
                n2_n2 = r1_pb - r1_pa;
            end
            DIR_DL: begin
                n2_n1 = r1_pb + r1_pa;
                n2_n2 = r1_pa - r1_pc;
            end
            DIR_DR: begin
                n2_n1 = r1_pa + r1_pc;
                n2_n2 = r1_pb + r1_pd;
            end
            DIR_UR: begin
                n2_n1 = r1_pb - r1_pd;
                n2_n2 = r1_pa + r1_pb;
            end
            default: begin
                n2_n1 = '0;
                n2_n2 = '0;
            end
        endcase
    end

    t_dir                 r2_dir;
    logic [CW-1:0]        r2_ux, r2_uy, r2_dx, r2_dy;
    logic signed [NW-1:0] r2_n1, r2_n2, r2_fdx, r2_fdy;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r2_dir <= r1_dir;
            r2_ux  <= r1_ux;
            r2_uy  <= r1_uy;
            r2_dx  <= r1_dx;
            r2_dy  <= r1_dy;
            r2_n1  <= n2_n1;
            r2_n2  <= n2_n2;
            r2_fdx <= r1_fdx;
            r2_fdy <= r1_fdy;
        end
    end

    // ---- Stage 3: exact range tests, pick the edge and the division ----
    t_work                n3_job;
    logic signed [NW-1:0] n3_num;
    logic signed [NW-1:0] n3_sdx, n3_sdy;
    logic                 n3_dl1, n3_dl2, n3_dy1, n3_dx1, n3_ul1, n3_ur2;

    always_comb begin
        n3_sdx = $signed({{(NW-CW){1'b0}}, r2_dx});
        n3_sdy = $signed({{(NW-CW){1'b0}}, r2_dy});
        n3_ul1 = (r2_n1 >= 0) && (r2_n1 < r2_fdy);
        n3_dl1 = (r2_n1 >= 0) && (r2_n1 < r2_fdx);
        n3_dl2 = (r2_n2 >= 0) && (r2_n2 < r2_fdy);
        n3_dy1 = (r2_n1 >= n3_sdy) && (r2_n1 < r2_fdy);
        n3_dx1 = (r2_n1 >= n3_sdx) && (r2_n1 < r2_fdx);
        n3_ur2 = (r2_n2 >= n3_sdy) && (r2_n2 < r2_fdy);

        n3_job        = '0;
        n3_job.code   = EDGE_NONE;
        n3_num        = r2_n1;
        unique case (r2_dir)
            DIR_COL_DN: begin
                n3_job.bx = r2_ux; n3_job.by = LP_FM1; n3_job.code = EDGE_BOTTOM_RIGHT;
            end
            DIR_COL_UP: begin
                n3_job.bx = r2_ux; n3_job.by = LP_ONE; n3_job.code = EDGE_TOP_LEFT;
            end
            DIR_ROW_R: begin
                n3_job.bx = LP_FM1; n3_job.by = r2_uy; n3_job.code = EDGE_RIGHT_TOP;
            end
            DIR_ROW_L: begin
                n3_job.bx = LP_ONE; n3_job.by = r2_uy; n3_job.code = EDGE_LEFT_BOTTOM;
            end
            DIR_UL: begin
                n3_job.div_on = 1'b1;
                if (n3_ul1) begin
                    n3_job.to_x = 1'b1; n3_job.raise = 1'b1; n3_job.den = r2_dy;
                    n3_job.by = LP_ONE; n3_job.code = EDGE_TOP_LEFT;
                end else begin
                    n3_num = r2_n2; n3_job.den = r2_dx;
                    n3_job.bx = LP_ONE; n3_job.code = EDGE_LEFT_TOP;
                end
            end
            DIR_DL: begin
                if (n3_dl1) begin
                    n3_job.div_on = 1'b1; n3_job.raise = 1'b1; n3_job.den = r2_dx;
                    n3_job.bx = LP_ONE; n3_job.code = EDGE_LEFT_BOTTOM;
                end else if (n3_dl2) begin
                    n3_num = r2_n2;
                    n3_job.div_on = 1'b1; n3_job.to_x = 1'b1; n3_job.raise = 1'b1;
                    n3_job.den = r2_dy; n3_job.by = LP_FM1; n3_job.code = EDGE_BOTTOM_LEFT;
                end
            end
            DIR_DR: begin
                n3_job.div_on = 1'b1;
                if (n3_dy1) begin
                    n3_job.to_x = 1'b1; n3_job.den = r2_dy;
                    n3_job.by = LP_FM1; n3_job.code = EDGE_BOTTOM_RIGHT;
                end else begin
                    n3_num = r2_n2; n3_job.den = r2_dx;
                    n3_job.bx = LP_FM1; n3_job.code = EDGE_RIGHT_BOTTOM;
                end
            end
            DIR_UR: begin
                if (n3_dx1) begin
                    n3_job.div_on = 1'b1; n3_job.den = r2_dx;
                    n3_job.bx = LP_FM1; n3_job.code = EDGE_RIGHT_TOP;
                end else if (n3_ur2) begin
                    n3_num = r2_n2;
                    n3_job.div_on = 1'b1; n3_job.to_x = 1'b1; n3_job.den = r2_dy;
                    n3_job.by = LP_ONE; n3_job.code = EDGE_TOP_RIGHT;
                end
            end
            default: begin
                n3_job.code = EDGE_NONE;
            end
        endcase
    end

    t_work                r3_job;
    logic signed [NW-1:0] r3_num;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r3_job <= n3_job;
            r3_num <= n3_num;
        end
    end

    // ---- Stage 4: divider setup; negative and too-large quotients saturate ----
    t_work n4_job;

    always_comb begin
        n4_job     = r3_job;
        n4_job.neg = r3_num < 0;
        n4_job.ovf = !n4_job.neg
                     && (r3_num >= ($signed({{(NW-CW){1'b0}}, r3_job.den}) <<< CW));
        n4_job.rem = (n4_job.neg || n4_job.ovf) ? '0 : r3_num[RW-1:0];
        n4_job.q   = '0;
    end

    t_work r_dw [0:DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_dw[0] <= n4_job;
        end
    end

    // ---- Divider stages: two quotient bits each, most significant first ----
    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        t_work n_step;
        always_comb begin
            n_step = div_step(div_step(r_dw[j], CW - 1 - BPS * j), CW - 2 - BPS * j);
        end
        always_ff @(posedge i_clk) begin
            if (w_en[4+j]) begin
                r_dw[j+1] <= n_step;
            end
        end
    end

    // ---- Output register: clamp, raise zero, place the quotient ----
    t_work         w_fin;
    logic [CW-1:0] n_q;
    logic [CW-1:0] r_bx, r_by;
    t_edge         r_code;

    always_comb begin
        w_fin = r_dw[DIV_STAGES];
        priority if (w_fin.neg) n_q = '0;
        else if (w_fin.ovf)     n_q = '1;
        else                    n_q = w_fin.q;
        if (w_fin.raise && n_q == '0) begin
            n_q = LP_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NS-1]) begin
            r_bx   <= (w_fin.div_on && w_fin.to_x)  ? n_q : w_fin.bx;
            r_by   <= (w_fin.div_on && !w_fin.to_x) ? n_q : w_fin.by;
            r_code <= w_fin.code;
        end
    end

    assign o_out.valid     = r_v[NS-1];
    assign o_out.border_x  = r_bx;
    assign o_out.border_y  = r_by;
    assign o_out.edge_code = r_code;

    // ---- Checks ----
    a_none_at_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NS-1] && r_code == EDGE_NONE) |-> (r_bx == '0 && r_by == '0))
        else $error("no-hit beat carries a nonzero border point");

    a_right_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NS-1] && (r_code == EDGE_RIGHT_TOP || r_code == EDGE_RIGHT_BOTTOM))
        |-> (r_bx == LP_FM1))
        else $error("right-edge beat not on the right column");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("output valid right after reset");

endmodule

### bench/tb_ray_to_border_projection_core.sv
// Self-checking bench for the ray-to-border projection core.
`timescale 1ns / 1ps
module tb_ray_to_border_projection_core import rbp_pkg::*; ();

    localparam int FSIZE       = 800;
    localparam int N_RANDOM    = 1030;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [CW-1:0] bx;
        logic [CW-1:0] by;
        t_edge         code;
    } t_border;

    // One directed row: the four coordinates, and a typed answer where one is given.
    typedef struct {
        int      vx, vy, tx, ty;
        bit      typed;
        t_border want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    rbp_in_if  in_ch ();
    rbp_out_if out_ch ();

    ray_to_border_projection_core #(.FIELD_SIZE(FSIZE)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_border border_queue[$];
    int      n_fail;
    int      n_sent;
    int      n_seen;
    int      idle_cycles;
    bit      stim_done;
    int      code_hits[9];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Saturate a signed intercept onto the 10-bit output range.
    function automatic logic [CW-1:0] clamp10(input longint v);
        if (v < 0) return '0;
        if (v > 1023) return '1;
        return CW'(v);
    endfunction

    // Exact test lo <= num/den < F with den positive.
    function automatic bit within_field(input longint num, input longint den,
                                        input longint lo);
        return num >= lo * den && num < longint'(FSIZE) * den;
    endfunction

    function automatic longint lift_zero(input longint v);
        return v == 0 ? 1 : v;
    endfunction

    // Predict where the ray from the viewer through the target leaves the field.
    function automatic t_border project_to_border(input logic [CW-1:0] vx_i,
            input logic [CW-1:0] vy_i, input logic [CW-1:0] tx_i,
            input logic [CW-1:0] ty_i);
        longint  ux, uy, px, py, f, bx, by, num, dx, dy;
        t_edge   code;
        t_border r;
        ux = vx_i; uy = vy_i; px = tx_i; py = ty_i; f = FSIZE;
        bx = 0; by = 0; code = EDGE_NONE;
        if (ux == px) begin
            if (uy < py) begin
                bx = ux; by = f - 1; code = EDGE_BOTTOM_RIGHT;
            end else if (uy > py) begin
                bx = ux; by = 1; code = EDGE_TOP_LEFT;
            end
        end else if (uy == py) begin
            if (ux < px) begin
                bx = f - 1; by = uy; code = EDGE_RIGHT_TOP;
            end else begin
                bx = 1; by = uy; code = EDGE_LEFT_BOTTOM;
            end
        end else if (uy > py && ux > px) begin
            dx = ux - px; dy = uy - py;
            num = ux * dy - dx * uy;
            if (within_field(num, dy, 0)) begin
                bx = lift_zero(num / dy); by = 1; code = EDGE_TOP_LEFT;
            end else begin
                bx = 1; by = (uy * dx - dy * ux) / dx; code = EDGE_LEFT_TOP;
            end
        end else if (uy < py && ux > px) begin
            dx = ux - px; dy = py - uy;
            num = uy * dx + dy * ux;
            if (within_field(num, dx, 0)) begin
                bx = 1; by = lift_zero(num / dx); code = EDGE_LEFT_BOTTOM;
            end else begin
                num = ux * dy - dx * (f - uy);
                if (within_field(num, dy, 0)) begin
                    bx = lift_zero(num / dy); by = f - 1; code = EDGE_BOTTOM_LEFT;
                end
            end
        end else if (uy < py && ux < px) begin
            dx = px - ux; dy = py - uy;
            num = ux * dy + dx * (f - uy);
            if (within_field(num, dy, 1)) begin
                bx = num / dy; by = f - 1; code = EDGE_BOTTOM_RIGHT;
            end else begin
                bx = f - 1; by = (uy * dx + dy * (f - ux)) / dx; code = EDGE_RIGHT_BOTTOM;
            end
        end else begin
            dx = px - ux; dy = uy - py;
            num = uy * dx - dy * (f - ux);
            if (within_field(num, dx, 1)) begin
                bx = f - 1; by = num / dx; code = EDGE_RIGHT_TOP;
            end else begin
                num = ux * dy + dx * uy;
                if (within_field(num, dy, 1)) begin
                    bx = num / dy; by = 1; code = EDGE_TOP_RIGHT;
                end
            end
        end
        r.bx = clamp10(bx);
        r.by = clamp10(by);
        r.code = code;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        n_fail++;
        $display("MISMATCH beat %0d %s: got %0d expected %0d", n_seen, what, got, want);
    endtask

    // After a random gap (none when no_gap is set), hold each beat until the core takes it.
    task automatic send_beat(input logic [CW-1:0] vx, input logic [CW-1:0] vy,
                             input logic [CW-1:0] tx, input logic [CW-1:0] ty,
                             input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.viewer_x <= vx;
        in_ch.viewer_y <= vy;
        in_ch.target_x <= tx;
        in_ch.target_y <= ty;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        border_queue = {border_queue, project_to_border(vx, vy, tx, ty)};
        n_sent++;
        @(negedge i_clk);
    endtask

    function automatic t_row mk_row(input int vx, vy, tx, ty, input bit typed = 0,
                                    input int bx = 0, by = 0, input t_edge code = EDGE_NONE);
        t_row r;
        r.vx = vx; r.vy = vy; r.tx = tx; r.ty = ty; r.typed = typed;
        r.want.bx = CW'(bx); r.want.by = CW'(by); r.want.code = code;
        return r;
    endfunction

    // Random coordinate: mostly on the field, sometimes near or past its edges.
    function automatic logic [CW-1:0] pick_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return CW'($urandom_range(0, FSIZE - 1));
        if (sel < 8) return CW'($urandom_range(0, 3));
        if (sel < 9) return CW'($urandom_range(FSIZE - 3, FSIZE - 1));
        return CW'($urandom_range(FSIZE, 1023));
    endfunction

    // Sink side: random stall per beat once 200 beats are sent, check each beat against the oldest prediction.
    initial begin
        int      wait_n;
        t_border want;
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(negedge i_clk);
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (n_sent < 200) wait_n = 0;
            if (wait_n > 0) begin
                out_ch.ready <= 1'b0;
                repeat (wait_n) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
            n_seen++;
            if (border_queue.size() == 0) begin
                report_mismatch("unexpected beat, edge code", out_ch.edge_code, -1);
            end else begin
                want = border_queue.pop_front();
                if (out_ch.border_x !== want.bx)
                    report_mismatch("border_x", out_ch.border_x, want.bx);
                if (out_ch.border_y !== want.by)
                    report_mismatch("border_y", out_ch.border_y, want.by);
                if (out_ch.edge_code !== want.code)
                    report_mismatch("edge_code", out_ch.edge_code, want.code);
                if (want.code <= EDGE_TOP_RIGHT) code_hits[want.code]++;
            end
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (stim_done && border_queue.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout with %0d beats outstanding", border_queue.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        t_border got;
        int i;
        n_fail = 0; n_sent = 0; stim_done = 0;
        in_ch.valid = 1'b0;
        in_ch.viewer_x = '0; in_ch.viewer_y = '0;
        in_ch.target_x = '0; in_ch.target_y = '0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Straight rays, identical points and extremes carry a typed answer.
        rows = {rows, mk_row(0, 0, 0, 0, 1, 0, 0, EDGE_NONE)};
        rows = {rows, mk_row(1023, 1023, 1023, 1023, 1, 0, 0, EDGE_NONE)};
        rows = {rows, mk_row(400, 100, 400, 700, 1, 400, 799, EDGE_BOTTOM_RIGHT)};
        rows = {rows, mk_row(400, 700, 400, 100, 1, 400, 1, EDGE_TOP_LEFT)};
        rows = {rows, mk_row(100, 300, 700, 300, 1, 799, 300, EDGE_RIGHT_TOP)};
        rows = {rows, mk_row(700, 300, 100, 300, 1, 1, 300, EDGE_LEFT_BOTTOM)};
        rows = {rows, mk_row(1023, 0, 1023, 1023, 1, 1023, 799, EDGE_BOTTOM_RIGHT)};
        rows = {rows, mk_row(0, 1023, 1023, 1023, 1, 799, 1023, EDGE_RIGHT_TOP)};
        rows = {rows, mk_row(0, 799, 0, 0, 1, 0, 1, EDGE_TOP_LEFT)};
        rows = {rows, mk_row(799, 0, 0, 0, 1, 1, 0, EDGE_LEFT_BOTTOM)};
        // Diagonals: each quadrant, both candidate edges, zero intercepts lifted to one.
        rows = {rows, mk_row(400, 400, 300, 300)};
        rows = {rows, mk_row(400, 100, 100, 50)};
        rows = {rows, mk_row(100, 400, 50, 100)};
        rows = {rows, mk_row(400, 400, 300, 500)};
        rows = {rows, mk_row(100, 700, 50, 799)};
        rows = {rows, mk_row(400, 400, 500, 500)};
        rows = {rows, mk_row(700, 100, 799, 150)};
        rows = {rows, mk_row(400, 400, 500, 300)};
        rows = {rows, mk_row(700, 700, 799, 600)};
        rows = {rows, mk_row(1, 1, 0, 0)};
        rows = {rows, mk_row(1, 798, 0, 799)};
        rows = {rows, mk_row(1000, 1000, 1023, 1023)};
        rows = {rows, mk_row(1023, 0, 0, 1023)};
        rows = {rows, mk_row(0, 1023, 1023, 0)};
        rows = {rows, mk_row(1023, 1023, 0, 0)};

        foreach (rows[k]) begin
            if (rows[k].typed) begin
                got = project_to_border(CW'(rows[k].vx), CW'(rows[k].vy),
                                        CW'(rows[k].tx), CW'(rows[k].ty));
                if (got !== rows[k].want)
                    report_mismatch("directed row prediction", k, k);
            end
            send_beat(CW'(rows[k].vx), CW'(rows[k].vy), CW'(rows[k].tx),
                      CW'(rows[k].ty), k < 12);
        end

        // Random part: a back-to-back burst first, then idling on both sides.
        for (i = 0; i < N_RANDOM; i++) begin
            if ($urandom_range(0, 15) == 0)
                send_beat(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom),
                          i < 150);
            else
                send_beat(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                          i < 150);
        end
        in_ch.valid <= 1'b0;
        stim_done = 1;

        while (border_queue.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        $display("Covered %0d beats; per edge code: %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                 n_sent, code_hits[0], code_hits[1], code_hits[2], code_hits[3],
                 code_hits[4], code_hits[5], code_hits[6], code_hits[7], code_hits[8]);
        $display("%0d beats returned, %0d mismatches", n_seen, n_fail);
        if (n_fail == 0 && n_seen == n_sent)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

### files.f
hw/rtl/rbp_pkg.sv
hw/rtl/rbp_if.sv
hw/rtl/ray_to_border_projection_core.sv
bench/tb_ray_to_border_projection_core.sv
